@@ src/pcpf_pkg.sv @@
// Shared types, codes and the multiply sequence of the collinear point filter.
package pcpf_pkg;

  localparam int COORD_W  = 32;
  localparam int KIND_W   = 4;
  localparam int TOL_W    = 16;
  localparam int TH_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int LIMB_W   = 32;
  localparam int OPND_W   = LIMB_W + 1;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int CAPT_W   = 4 * LIMB_W;
  localparam int ACC_W    = 176;
  localparam int NSTEPS   = 30;
  localparam int STEP_W   = 5;

  localparam logic [CFG_IDX_W-1:0] REG_DUP_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_TH  = 2'd1;
  localparam logic [TOL_W-1:0] DUP_TOL_RST = 16'd1;
  localparam logic [TH_W-1:0]  COS_TH_RST  = 32'd4294958706;

  typedef enum logic [3:0] {
    SRC_X1, SRC_Y1, SRC_X2, SRC_Y2, SRC_DOT, SRC_N1, SRC_N2, SRC_T, SRC_TH
  } src_t;

  typedef enum logic [2:0] {
    CAP_NONE, CAP_DOT, CAP_N1, CAP_N2, CAP_T
  } cap_t;

  typedef enum logic [1:0] {
    WIN_NONE, WIN_NEWER, WIN_SHIFT
  } win_t;

  typedef struct packed {
    src_t       a_src;
    logic [1:0] a_ch;
    src_t       b_src;
    logic [1:0] b_ch;
    logic [2:0] shift;
    logic       clr;
    logic       sub;
    cap_t       cap;
  } step_t;

  typedef struct packed {
    logic  load_pt;
    logic  calc_diff;
    logic  mul_go;
    step_t step;
    win_t  win;
    logic  load_out;
    logic  out_older;
    logic  out_final;
  } cmd_t;

  typedef struct packed {
    logic same_spot;
    logic colinear;
    logic kind_match;
    logic last;
    logic out_free;
  } stat_t;

  function automatic step_t mk(src_t a, logic [1:0] ac, src_t b, logic [1:0] bc,
                               logic [2:0] sh, logic clr, logic sub, cap_t cap);
    step_t s;
    s.a_src = a; s.a_ch = ac; s.b_src = b; s.b_ch = bc;
    s.shift = sh; s.clr = clr; s.sub = sub; s.cap = cap;
    return s;
  endfunction

  // The comparison dot^2 * 2^32 - th * n1 * n2 is built in one accumulator.
  function automatic step_t mstep(logic [STEP_W-1:0] idx);
    step_t s;
    unique case (idx)
      5'd0:  s = mk(SRC_X1, 2'd0, SRC_X2, 2'd0, 3'd0, 1'b1, 1'b0, CAP_NONE);
      5'd1:  s = mk(SRC_Y1, 2'd0, SRC_Y2, 2'd0, 3'd0, 1'b0, 1'b0, CAP_DOT);
      5'd2:  s = mk(SRC_X1, 2'd0, SRC_X1, 2'd0, 3'd0, 1'b1, 1'b0, CAP_NONE);
      5'd3:  s = mk(SRC_Y1, 2'd0, SRC_Y1, 2'd0, 3'd0, 1'b0, 1'b0, CAP_N1);
      5'd4:  s = mk(SRC_X2, 2'd0, SRC_X2, 2'd0, 3'd0, 1'b1, 1'b0, CAP_NONE);
      5'd5:  s = mk(SRC_Y2, 2'd0, SRC_Y2, 2'd0, 3'd0, 1'b0, 1'b0, CAP_N2);
      5'd6:  s = mk(SRC_N1, 2'd0, SRC_TH, 2'd0, 3'd0, 1'b1, 1'b0, CAP_NONE);
      5'd7:  s = mk(SRC_N1, 2'd1, SRC_TH, 2'd0, 3'd1, 1'b0, 1'b0, CAP_NONE);
      5'd8:  s = mk(SRC_N1, 2'd2, SRC_TH, 2'd0, 3'd2, 1'b0, 1'b0, CAP_T);
      5'd9:  s = mk(SRC_DOT, 2'd0, SRC_DOT, 2'd0, 3'd1, 1'b1, 1'b0, CAP_NONE);
      5'd10: s = mk(SRC_DOT, 2'd0, SRC_DOT, 2'd1, 3'd2, 1'b0, 1'b0, CAP_NONE);
      5'd11: s = mk(SRC_DOT, 2'd0, SRC_DOT, 2'd2, 3'd3, 1'b0, 1'b0, CAP_NONE);
      5'd12: s = mk(SRC_DOT, 2'd1, SRC_DOT, 2'd0, 3'd2, 1'b0, 1'b0, CAP_NONE);
      5'd13: s = mk(SRC_DOT, 2'd1, SRC_DOT, 2'd1, 3'd3, 1'b0, 1'b0, CAP_NONE);
      5'd14: s = mk(SRC_DOT, 2'd1, SRC_DOT, 2'd2, 3'd4, 1'b0, 1'b0, CAP_NONE);
      5'd15: s = mk(SRC_DOT, 2'd2, SRC_DOT, 2'd0, 3'd3, 1'b0, 1'b0, CAP_NONE);
      5'd16: s = mk(SRC_DOT, 2'd2, SRC_DOT, 2'd1, 3'd4, 1'b0, 1'b0, CAP_NONE);
      5'd17: s = mk(SRC_DOT, 2'd2, SRC_DOT, 2'd2, 3'd5, 1'b0, 1'b0, CAP_NONE);
      5'd18: s = mk(SRC_T, 2'd0, SRC_N2, 2'd0, 3'd0, 1'b0, 1'b1, CAP_NONE);
      5'd19: s = mk(SRC_T, 2'd0, SRC_N2, 2'd1, 3'd1, 1'b0, 1'b1, CAP_NONE);
      5'd20: s = mk(SRC_T, 2'd0, SRC_N2, 2'd2, 3'd2, 1'b0, 1'b1, CAP_NONE);
      5'd21: s = mk(SRC_T, 2'd1, SRC_N2, 2'd0, 3'd1, 1'b0, 1'b1, CAP_NONE);
      5'd22: s = mk(SRC_T, 2'd1, SRC_N2, 2'd1, 3'd2, 1'b0, 1'b1, CAP_NONE);
      5'd23: s = mk(SRC_T, 2'd1, SRC_N2, 2'd2, 3'd3, 1'b0, 1'b1, CAP_NONE);
      5'd24: s = mk(SRC_T, 2'd2, SRC_N2, 2'd0, 3'd2, 1'b0, 1'b1, CAP_NONE);
      5'd25: s = mk(SRC_T, 2'd2, SRC_N2, 2'd1, 3'd3, 1'b0, 1'b1, CAP_NONE);
      5'd26: s = mk(SRC_T, 2'd2, SRC_N2, 2'd2, 3'd4, 1'b0, 1'b1, CAP_NONE);
      5'd27: s = mk(SRC_T, 2'd3, SRC_N2, 2'd0, 3'd3, 1'b0, 1'b1, CAP_NONE);
      5'd28: s = mk(SRC_T, 2'd3, SRC_N2, 2'd1, 3'd4, 1'b0, 1'b1, CAP_NONE);
      5'd29: s = mk(SRC_T, 2'd3, SRC_N2, 2'd2, 3'd5, 1'b0, 1'b1, CAP_NONE);
      default: s = mk(SRC_X1, 2'd0, SRC_X1, 2'd0, 3'd0, 1'b0, 1'b0, CAP_NONE);
    endcase
    return s;
  endfunction

endpackage

@@ src/pcpf_pt_if.sv @@
// Input point channel.
interface pcpf_pt_if;
  import pcpf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pt_x;
  logic signed [COORD_W-1:0] pt_y;
  logic [KIND_W-1:0]         pt_kind;
  logic                      pt_last;
  modport source(output valid, pt_x, pt_y, pt_kind, pt_last, input ready);
  modport sink(input valid, pt_x, pt_y, pt_kind, pt_last, output ready);
endinterface

@@ src/pcpf_res_if.sv @@
// Kept point result channel.
interface pcpf_res_if;
  import pcpf_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic [KIND_W-1:0]         out_kind;
  logic                      out_final;
  modport source(output valid, out_x, out_y, out_kind, out_final, input ready);
  modport sink(input valid, out_x, out_y, out_kind, out_final, output ready);
endinterface

@@ src/pcpf_cfg_if.sv @@
// Configuration register write channel.
interface pcpf_cfg_if;
  import pcpf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ src/pcpf_dp.sv @@
// Datapath: point window, registers, shared multiplier with accumulator, output register.
module pcpf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcpf_pkg::cmd_t               cmd,
  output pcpf_pkg::stat_t              stat,
  input  logic signed [pcpf_pkg::COORD_W-1:0] in_x,
  input  logic signed [pcpf_pkg::COORD_W-1:0] in_y,
  input  logic [pcpf_pkg::KIND_W-1:0]  in_kind,
  input  logic                         in_last,
  input  logic                         cfg_we,
  input  logic [pcpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcpf_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [pcpf_pkg::COORD_W-1:0] out_x,
  output logic signed [pcpf_pkg::COORD_W-1:0] out_y,
  output logic [pcpf_pkg::KIND_W-1:0]  out_kind,
  output logic                         out_final
);
  import pcpf_pkg::*;

  logic [TOL_W-1:0] tol_r;
  logic [TH_W-1:0]  th_r;
  logic signed [COORD_W-1:0] px_r, py_r, ox_r, oy_r, nx_r, ny_r;
  logic [KIND_W-1:0] pk_r, ok_r, nk_r;
  logic              plast_r;
  logic signed [DIFF_W-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        mx, my;
  logic [CAPT_W-1:0] dot_r, n1_r, n2_r, t_r;
  logic signed [OPND_W-1:0] opa, opb;
  logic signed [PROD_W-1:0] prod_r;
  logic       p_vld_r, p_clr_r, p_sub_r;
  logic [2:0] p_sh_r;
  cap_t       p_cap_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, addend;
  logic       ov_r;
  logic signed [COORD_W-1:0] oxo_r, oyo_r;
  logic [KIND_W-1:0] oko_r;
  logic       ofin_r;

  function automatic logic signed [OPND_W-1:0] opnd(src_t s, logic [1:0] c);
    logic signed [OPND_W-1:0] v;
    unique case (s)
      SRC_X1:  v = x1_r;
      SRC_Y1:  v = y1_r;
      SRC_X2:  v = x2_r;
      SRC_Y2:  v = y2_r;
      SRC_DOT: v = {1'b0, dot_r[c*LIMB_W +: LIMB_W]};
      SRC_N1:  v = {1'b0, n1_r[c*LIMB_W +: LIMB_W]};
      SRC_N2:  v = {1'b0, n2_r[c*LIMB_W +: LIMB_W]};
      SRC_T:   v = {1'b0, t_r[c*LIMB_W +: LIMB_W]};
      SRC_TH:  v = {1'b0, th_r};
      default: v = '0;
    endcase
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= DUP_TOL_RST;
      th_r  <= COS_TH_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_DUP_TOL) tol_r <= cfg_data[TOL_W-1:0];
      if (cfg_index == REG_COS_TH)  th_r  <= cfg_data[TH_W-1:0];
    end
  end

  assign dx = $signed({px_r[COORD_W-1], px_r}) - $signed({nx_r[COORD_W-1], nx_r});
  assign dy = $signed({py_r[COORD_W-1], py_r}) - $signed({ny_r[COORD_W-1], ny_r});
  assign mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      px_r <= in_x; py_r <= in_y; pk_r <= in_kind; plast_r <= in_last;
    end
    if (cmd.calc_diff) begin
      x1_r <= $signed({nx_r[COORD_W-1], nx_r}) - $signed({ox_r[COORD_W-1], ox_r});
      y1_r <= $signed({ny_r[COORD_W-1], ny_r}) - $signed({oy_r[COORD_W-1], oy_r});
      x2_r <= dx;
      y2_r <= dy;
    end
    unique case (cmd.win)
      WIN_NEWER: begin
        nx_r <= px_r; ny_r <= py_r; nk_r <= pk_r;
      end
      WIN_SHIFT: begin
        ox_r <= nx_r; oy_r <= ny_r; ok_r <= nk_r;
        nx_r <= px_r; ny_r <= py_r; nk_r <= pk_r;
      end
      default: begin
      end
    endcase
  end

  assign opa = opnd(cmd.step.a_src, cmd.step.a_ch);
  assign opb = opnd(cmd.step.b_src, cmd.step.b_ch);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= opa * opb;
    p_clr_r <= cmd.step.clr;
    p_sub_r <= cmd.step.sub;
    p_sh_r  <= cmd.step.shift;
    p_cap_r <= cmd.step.cap;
  end

  always_comb begin
    addend  = ACC_W'(prod_r) <<< (LIMB_W * p_sh_r);
    acc_nxt = (p_clr_r ? '0 : acc_r) + (p_sub_r ? -addend : addend);
  end

  always_ff @(posedge clk) begin
    if (p_vld_r) begin
      acc_r <= acc_nxt;
      unique case (p_cap_r)
        CAP_DOT: dot_r <= acc_nxt[CAPT_W-1:0];
        CAP_N1:  n1_r  <= acc_nxt[CAPT_W-1:0];
        CAP_N2:  n2_r  <= acc_nxt[CAPT_W-1:0];
        CAP_T:   t_r   <= acc_nxt[CAPT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_out) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      oxo_r  <= cmd.out_older ? ox_r : nx_r;
      oyo_r  <= cmd.out_older ? oy_r : ny_r;
      oko_r  <= cmd.out_older ? ok_r : nk_r;
      ofin_r <= cmd.out_final;
    end
  end

  assign stat.same_spot  = (mx < DIFF_W'(tol_r)) && (my < DIFF_W'(tol_r));
  assign stat.colinear   = !dot_r[CAPT_W-1] && (dot_r != '0) &&
                           !acc_r[ACC_W-1] && (acc_r != '0);
  assign stat.kind_match = (pk_r == nk_r) && (pk_r == ok_r);
  assign stat.last       = plast_r;
  assign stat.out_free   = !ov_r || out_ready;

  assign out_valid = ov_r;
  assign out_x     = oxo_r;
  assign out_y     = oyo_r;
  assign out_kind  = oko_r;
  assign out_final = ofin_r;
endmodule

@@ src/pcpf_ctrl.sv @@
// Controller state machine: window bookkeeping, multiply sequencing and emission.
module pcpf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pcpf_pkg::stat_t  stat,
  output pcpf_pkg::cmd_t   cmd
);
  import pcpf_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECIDE    = 4'd1;
  localparam logic [3:0] S_MUL       = 4'd2;
  localparam logic [3:0] S_DRAIN     = 4'd3;
  localparam logic [3:0] S_RESOLVE   = 4'd4;
  localparam logic [3:0] S_EMIT      = 4'd5;
  localparam logic [3:0] S_LAST      = 4'd6;
  localparam logic [3:0] S_FLUSH_OLD = 4'd7;
  localparam logic [3:0] S_FLUSH_NEW = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        held_r, held_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= 2'd0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      step_r  <= step_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.step  = mstep(step_r);
    cmd.win   = WIN_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_pt = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.calc_diff = 1'b1;
        state_nxt     = S_LAST;
        if (held_r == 2'd0) begin
          cmd.win  = WIN_NEWER;
          held_nxt = 2'd1;
        end else if (!stat.same_spot) begin
          if (held_r == 2'd1) begin
            cmd.win  = WIN_SHIFT;
            held_nxt = 2'd2;
          end else begin
            step_nxt  = '0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd.mul_go = 1'b1;
        step_nxt   = step_r + STEP_W'(1);
        if (step_r == STEP_W'(NSTEPS - 1)) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_RESOLVE;
      S_RESOLVE: begin
        if (stat.colinear && stat.kind_match) begin
          cmd.win   = WIN_NEWER;
          state_nxt = S_LAST;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_older = 1'b1;
          cmd.win       = WIN_SHIFT;
          state_nxt     = S_LAST;
        end
      end
      S_LAST: begin
        if (!stat.last) state_nxt = S_IDLE;
        else if (held_r == 2'd2) state_nxt = S_FLUSH_OLD;
        else state_nxt = S_FLUSH_NEW;
      end
      S_FLUSH_OLD: begin
        if (stat.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_older = 1'b1;
          state_nxt     = S_FLUSH_NEW;
        end
      end
      S_FLUSH_NEW: begin
        if (stat.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.out_final = 1'b1;
          held_nxt      = 2'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

@@ src/polyline_collinear_point_filter_unit.sv @@
// Top level of the polyline collinear point filter.
//
// Points enter on in_pt, kept points leave on out_res, and cfg_wr writes the
// duplicate tolerance (index 0) and the squared cosine threshold (index 1).
// Every channel moves one beat when valid and ready are both high; cfg_wr is
// always ready and should only be written while no point is in flight.
// A point that lands in a one- or two-point window, or is a duplicate, passes
// through the decide and last states and, unless it is a last point, returns
// to idle, where in_ready is high again. A point tested for collinearity runs
// 30 steps through one shared 33 by 33 bit signed multiplier and its
// accumulator, and in_ready stays low until the block is back in its idle
// state. A last point also flushes the held points, and every emit or flush
// waits while the output register is still full.
// Results sit in an output register; a stalled receiver holds the block in
// its emit or flush state until the beat is taken, and no result is dropped.
// Synchronous reset empties the window, clears the output valid and restores
// both registers to their defaults.
module polyline_collinear_point_filter_unit (
  input  logic    clk,
  input  logic    rst_n,
  pcpf_pt_if.sink     in_pt,
  pcpf_res_if.source  out_res,
  pcpf_cfg_if.sink    cfg_wr
);
  import pcpf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_wr.ready = 1'b1;

  pcpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_pt.valid),
    .in_ready (in_pt.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcpf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_x      (in_pt.pt_x),
    .in_y      (in_pt.pt_y),
    .in_kind   (in_pt.pt_kind),
    .in_last   (in_pt.pt_last),
    .cfg_we    (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_x     (out_res.out_x),
    .out_y     (out_res.out_y),
    .out_kind  (out_res.out_kind),
    .out_final (out_res.out_final)
  );
endmodule

@@ src/pcpf_checker.sv @@
// Port-level checker of the collinear point filter and its bind.
module pcpf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again in the cycle after a beat");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
endmodule

bind polyline_collinear_point_filter_unit pcpf_checker u_pcpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pt.valid),
  .in_ready  (in_pt.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready)
);

@@ tb/tb.sv @@
// Self-checking testbench for the polyline collinear point filter unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcpf_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [KIND_W-1:0]         kind;
    logic                      fin;
  } kept_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [3:0]  kind;
    logic        last;
    int          n_typed;
    kept_t       typed;
  } row_t;

  logic clk;
  logic rst_n;
  pcpf_pt_if  in_pt();
  pcpf_res_if out_res();
  pcpf_cfg_if cfg_wr();

  polyline_collinear_point_filter_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_pt(in_pt), .out_res(out_res), .cfg_wr(cfg_wr)
  );

  kept_t kept_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  logic [TOL_W-1:0] tol_m;
  logic [TH_W-1:0]  th_m;
  int               held_m;
  kept_t            older_m, newer_m;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic near_pt(kept_t a, kept_t b);
    logic signed [COORD_W:0] dx, dy;
    logic [COORD_W:0] ax, ay;
    dx = $signed({a.x[COORD_W-1], a.x}) - $signed({b.x[COORD_W-1], b.x});
    dy = $signed({a.y[COORD_W-1], a.y}) - $signed({b.y[COORD_W-1], b.y});
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    return ax < tol_m && ay < tol_m;
  endfunction

  function automatic logic in_line(kept_t a, kept_t b, kept_t c);
    logic signed [69:0] x1, y1, x2, y2, dot;
    logic [69:0] n1, n2;
    logic [199:0] lhs, rhs;
    x1 = 70'(b.x) - 70'(a.x);
    y1 = 70'(b.y) - 70'(a.y);
    x2 = 70'(c.x) - 70'(b.x);
    y2 = 70'(c.y) - 70'(b.y);
    dot = x1 * x2 + y1 * y2;
    if (dot <= 0) return 1'b0;
    n1 = 70'(x1 * x1 + y1 * y1);
    n2 = 70'(x2 * x2 + y2 * y2);
    lhs = 200'(dot) * 200'(dot);
    lhs = lhs << 32;
    rhs = 200'(th_m) * 200'(n1) * 200'(n2);
    return lhs > rhs;
  endfunction

  function automatic void emit(kept_t p, logic fin);
    kept_t r;
    r = p;
    r.fin = fin;
    kept_q.push_back(r);
  endfunction

  function automatic void filter_point(row_t r);
    kept_t p;
    p.x = r.x; p.y = r.y; p.kind = r.kind; p.fin = 1'b0;
    if (held_m == 0) begin
      newer_m = p;
      held_m = 1;
    end else if (held_m == 1) begin
      if (!near_pt(newer_m, p)) begin
        older_m = newer_m;
        newer_m = p;
        held_m = 2;
      end
    end else if (!near_pt(newer_m, p)) begin
      if (in_line(older_m, newer_m, p) && p.kind == newer_m.kind &&
          p.kind == older_m.kind) begin
        newer_m = p;
      end else begin
        emit(older_m, 1'b0);
        older_m = newer_m;
        newer_m = p;
      end
    end
    if (r.last) begin
      if (held_m >= 2) emit(older_m, 1'b0);
      emit(newer_m, 1'b1);
      held_m = 0;
    end
  endfunction

  task automatic send_point(row_t r);
    int n0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
    in_pt.valid   <= 1'b1;
    in_pt.pt_x    <= r.x;
    in_pt.pt_y    <= r.y;
    in_pt.pt_kind <= r.kind;
    in_pt.pt_last <= r.last;
    do @(posedge clk); while (!in_pt.ready);
    n0 = kept_q.size();
    filter_point(r);
    if (r.n_typed >= 0) begin
      while (kept_q.size() > n0) kept_q.delete(kept_q.size() - 1);
      if (r.n_typed > 0) kept_q.push_back(r.typed);
    end
  endtask

  task automatic drain();
    in_pt.valid <= 1'b0;
    @(posedge clk);
    wait (kept_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    cfg_wr.valid <= 1'b0;
    if (idx == REG_DUP_TOL) tol_m = val[TOL_W-1:0];
    else th_m = val[TH_W-1:0];
    @(posedge clk);
  endtask

  function automatic row_t mk_row(logic [31:0] x, logic [31:0] y, logic [3:0] k,
                                  logic last);
    row_t r;
    r.x = x; r.y = y; r.kind = k; r.last = last; r.n_typed = -1;
    r.typed = '{x: x, y: y, kind: k, fin: 1'b1};
    return r;
  endfunction

  function automatic row_t typed_row(logic [31:0] x, logic [31:0] y, logic [3:0] k);
    row_t r;
    r = mk_row(x, y, k, 1'b1);
    r.n_typed = 1;
    return r;
  endfunction

  task automatic random_line();
    int len, i;
    logic [31:0] px, py, sx, sy;
    logic [3:0] k;
    row_t r;
    len = $urandom_range(1, 6);
    k = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8));
    if ($urandom_range(3) == 0) begin
      px = $urandom; py = $urandom;
    end else begin
      px = $urandom_range(65535) - 32768; py = $urandom_range(65535) - 32768;
    end
    sx = $urandom_range(4095) - 2048;
    sy = $urandom_range(4095) - 2048;
    if ($urandom_range(7) == 0) begin
      sx = sx << 16; sy = sy << 16;
    end
    for (i = 0; i < len; i++) begin
      r = mk_row(px, py, k, i == len - 1);
      if ($urandom_range(9) == 0) r.kind = 4'($urandom);
      if ($urandom_range(19) == 0) begin
        r.x = $urandom; r.y = $urandom;
      end
      send_point(r);
      case ($urandom_range(9))
        0: ;
        1: begin
          px = px + $urandom_range(2); py = py + $urandom_range(2);
        end
        2: begin
          px = px + sx + $urandom_range(255); py = py - sy;
        end
        default: begin
          px = px + sx; py = py + sy;
        end
      endcase
    end
  endtask

  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    kept_t e;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (kept_q.size() == 0) begin
        $error("unexpected beat x=%h y=%h", out_res.out_x, out_res.out_y);
        errors++;
      end else begin
        e = kept_q.pop_front();
        if (out_res.out_x !== e.x) begin
          $error("out_x expected %h got %h", e.x, out_res.out_x); errors++;
        end
        if (out_res.out_y !== e.y) begin
          $error("out_y expected %h got %h", e.y, out_res.out_y); errors++;
        end
        if (out_res.out_kind !== e.kind) begin
          $error("out_kind expected %h got %h", e.kind, out_res.out_kind); errors++;
        end
        if (out_res.out_final !== e.fin) begin
          $error("out_final expected %b got %b", e.fin, out_res.out_final); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_pt.valid && in_pt.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t dir_rows[$];
    int ph, n;
    int stall_tab[4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{21, 21}};
    logic [15:0] tol_tab[4] = '{16'd1, 16'd0, 16'hFFFF, 16'd16};
    logic [31:0] th_tab[4] = '{COS_TH_RST, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_0000};

    in_pt.valid = 1'b0; in_pt.pt_x = '0; in_pt.pt_y = '0;
    in_pt.pt_kind = '0; in_pt.pt_last = 1'b0;
    cfg_wr.valid = 1'b0; cfg_wr.index = REG_DUP_TOL; cfg_wr.data = '0;
    tol_m = DUP_TOL_RST; th_m = COS_TH_RST; held_m = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_rows = '{
      typed_row(32'h7FFF_FFFF, 32'h8000_0000, 4'd8),
      typed_row(32'h8000_0000, 32'h7FFF_FFFF, 4'd0),
      mk_row(32'h0, 32'h0, 4'd1, 1'b0),
      mk_row(32'h1_0000, 32'h0, 4'd1, 1'b0),
      mk_row(32'h2_0000, 32'h0, 4'd1, 1'b1),
      mk_row(32'h0, 32'h0, 4'd2, 1'b0),
      typed_row(32'h0, 32'h0, 4'd2),
      mk_row(32'h0, 32'h0, 4'd3, 1'b0),
      mk_row(32'h1_0000, 32'h0, 4'd3, 1'b0),
      mk_row(32'h2_0000, 32'h0, 4'd4, 1'b0),
      mk_row(32'h3_0000, 32'h0, 4'd4, 1'b1),
      mk_row(32'h0, 32'h0, 4'd1, 1'b0),
      mk_row(32'h1_0000, 32'h0, 4'd1, 1'b0),
      mk_row(32'h1_0000, 32'h1_0000, 4'd1, 1'b0),
      mk_row(32'h0, 32'h1_0000, 4'd1, 1'b1),
      mk_row(32'h0, 32'h0, 4'd5, 1'b0),
      mk_row(32'h1_0000, 32'h0, 4'd5, 1'b0),
      mk_row(32'h0, 32'h0, 4'd5, 1'b1),
      mk_row(32'd5, 32'd5, 4'd15, 1'b0),
      mk_row(32'd100, 32'd100, 4'd15, 1'b0),
      mk_row(32'd200, 32'd200, 4'd15, 1'b1),
      mk_row(32'h8000_0000, 32'h8000_0000, 4'd7, 1'b0),
      mk_row(32'h0, 32'h0, 4'd7, 1'b0),
      mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd7, 1'b1)
    };
    foreach (dir_rows[i]) send_point(dir_rows[i]);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      write_reg(REG_DUP_TOL, 32'(tol_tab[ph]));
      write_reg(REG_COS_TH, th_tab[ph]);
      send_idle_pct = stall_tab[ph][0];
      recv_stall_pct = stall_tab[ph][1];
      if (ph == 0) hold_cycles = 600;
      n = 0;
      while (n < 10) begin
        random_line();
        n++;
      end
      drain();
    end

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

@@ filelist.f @@
src/pcpf_pkg.sv
src/pcpf_pt_if.sv
src/pcpf_res_if.sv
src/pcpf_cfg_if.sv
src/pcpf_dp.sv
src/pcpf_ctrl.sv
src/polyline_collinear_point_filter_unit.sv
src/pcpf_checker.sv
tb/tb.sv
